// ----- hw/rtl/gtls_pkg.sv -----
// shared types, register codes, constants and tables for the gel scattering pipeline
`default_nettype none

package gtls_pkg;

  localparam int CFG_W = 32;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_LORENTZ_SCALE      = 3'd0;
  localparam logic [IDX_W-1:0] REG_GUINIER_SCALE      = 3'd1;
  localparam logic [IDX_W-1:0] REG_CORRELATION_LENGTH = 3'd2;
  localparam logic [IDX_W-1:0] REG_GYRATION_RADIUS    = 3'd3;
  localparam logic [IDX_W-1:0] REG_SCALING_EXPONENT   = 3'd4;
  localparam logic [IDX_W-1:0] REG_BACKGROUND_LEVEL   = 3'd5;

  localparam logic signed [31:0] RST_LORENTZ_SCALE      = 32'sd229376;
  localparam logic signed [31:0] RST_GUINIER_SCALE      = 32'sd111411;
  localparam logic [23:0]        RST_CORRELATION_LENGTH = 24'd65536;
  localparam logic [23:0]        RST_GYRATION_RADIUS    = 24'd425984;
  localparam logic signed [15:0] RST_SCALING_EXPONENT   = 16'sd8192;
  localparam logic signed [31:0] RST_BACKGROUND_LEVEL   = 32'sd655;

  // exponent used when the programmed one is not positive
  localparam logic [14:0] EXP_DEFAULT = 15'd8192;
  localparam logic [15:0] ONE_Q12     = 16'd4096;
  localparam logic [30:0] LOG2E_Q30   = 31'd1549082005;

  localparam int FRAC_BITS  = 24;
  localparam int DIV_STAGES = 8;
  localparam int LOG_STAGES = FRAC_BITS + 2;
  localparam int LATENCY    = 72;

  typedef struct packed {
    logic signed [23:0] qx;
    logic signed [23:0] qy;
  } in_t;

  typedef struct packed {
    logic signed [31:0] intensity;
    logic               saturated;
  } out_t;

  typedef logic [FRAC_BITS:1][30:0] root_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] xv;
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] trial;
    xv    = x;
    res   = '0;
    bit_v = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      trial = res + bit_v;
      if (xv >= trial) begin
        xv  = xv - trial;
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-i) in Q.30 for i = 1..FRAC_BITS, by repeated square roots of one half
  function automatic root_tab_t root_table();
    root_tab_t   t;
    logic [63:0] r;
    r = 64'd1 << 29;
    for (int i = 1; i <= FRAC_BITS; i++) begin
      r    = isqrt64(r << 30);
      t[i] = r[30:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOT_TAB = root_table();

  // one byte of a divide by three: returns {quotient byte, remainder}
  function automatic logic [9:0] div3_step(input logic [1:0] rem, input logic [7:0] chunk);
    logic [9:0]  cur;
    logic [19:0] p;
    logic [7:0]  q;
    logic [9:0]  r;
    cur = {rem, chunk};
    p   = cur * 20'd683;
    q   = p[18:11];
    r   = cur - {q, 1'b0} - {2'b00, q};
    return {q, r[1:0]};
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gtls_log2.sv -----
// pipelined base-2 logarithm: two normalise stages then one squaring per fraction bit
`default_nettype none

module gtls_log2 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [57:0] in_b,
  output logic        out_valid,
  output logic [29:0] out_log
);
  import gtls_pkg::*;

  logic [63:0] w0;
  logic [2:0]  lz0;
  logic [63:0] n1_w_r;
  logic [2:0]  n1_lz_r;
  logic        n1_v_r;
  logic [63:0] w1;
  logic [2:0]  lz_low;
  logic [63:0] n2_w_r;
  logic [5:0]  n2_lz_r;
  logic        n2_v_r;

  logic [30:0]          m_r  [1:FRAC_BITS];
  logic [FRAC_BITS-1:0] fr_r [1:FRAC_BITS];
  logic [5:0]           ip_r [1:FRAC_BITS];
  logic [FRAC_BITS:1]   v_r;

  // leading zero count of the high three steps
  always_comb begin
    w0  = {6'b0, in_b};
    lz0 = '0;
    if (w0[63:32] == '0) begin
      w0     = w0 << 32;
      lz0[2] = 1'b1;
    end
    if (w0[63:48] == '0) begin
      w0     = w0 << 16;
      lz0[1] = 1'b1;
    end
    if (w0[63:56] == '0) begin
      w0     = w0 << 8;
      lz0[0] = 1'b1;
    end
  end

  // leading zero count of the low three steps
  always_comb begin
    w1     = n1_w_r;
    lz_low = '0;
    if (w1[63:60] == '0) begin
      w1        = w1 << 4;
      lz_low[2] = 1'b1;
    end
    if (w1[63:62] == '0) begin
      w1        = w1 << 2;
      lz_low[1] = 1'b1;
    end
    if (w1[63] == 1'b0) begin
      w1        = w1 << 1;
      lz_low[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_v_r <= 1'b0;
      n2_v_r <= 1'b0;
    end else begin
      n1_v_r <= in_valid;
      n2_v_r <= n1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    n1_w_r  <= w0;
    n1_lz_r <= lz0;
    n2_w_r  <= w1;
    n2_lz_r <= {n1_lz_r, lz_low};
  end

  for (genvar i = 1; i <= FRAC_BITS; i++) begin : g_sq
    logic [30:0]          m_in;
    logic [FRAC_BITS-1:0] fr_in;
    logic [5:0]           ip_in;
    logic                 v_in;
    logic [61:0]          sq;
    logic [31:0]          hi;
    logic [FRAC_BITS-1:0] fr_set;

    if (i == 1) begin : g_head
      assign m_in  = n2_w_r[63:33];
      assign fr_in = '0;
      assign ip_in = 6'd39 - n2_lz_r;
      assign v_in  = n2_v_r;
    end else begin : g_body
      assign m_in  = m_r[i-1];
      assign fr_in = fr_r[i-1];
      assign ip_in = ip_r[i-1];
      assign v_in  = v_r[i-1];
    end

    assign sq = m_in * m_in;
    assign hi = sq[61:30];

    always_comb begin
      fr_set                = fr_in;
      fr_set[FRAC_BITS - i] = hi[31];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      m_r[i]  <= hi[31] ? hi[31:1] : hi[30:0];
      fr_r[i] <= fr_set;
      ip_r[i] <= ip_in;
    end
  end

  assign out_valid = v_r[FRAC_BITS];
  assign out_log   = {ip_r[FRAC_BITS], fr_r[FRAC_BITS]};

endmodule

`default_nettype wire

// ----- hw/rtl/gtls_pow2.sv -----
// pipelined 2^(-e): one conditional multiply by a root constant per fraction bit, then a shift
`default_nettype none

module gtls_pow2 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [53:0] in_e,
  output logic        out_valid,
  output logic [30:0] out_f
);
  import gtls_pkg::*;

  logic [30:0]          acc_r [1:FRAC_BITS];
  logic [FRAC_BITS-1:0] fr_r  [1:FRAC_BITS];
  logic [4:0]           n_r   [1:FRAC_BITS];
  logic                 big_r [1:FRAC_BITS];
  logic [FRAC_BITS:1]   v_r;
  logic                 f_v_r;
  logic [30:0]          f_r;
  logic                 in_big;

  // integer part of 31 or more flushes to zero
  assign in_big = (|in_e[53:29]) || (&in_e[28:24]);

  for (genvar i = 1; i <= FRAC_BITS; i++) begin : g_mul
    logic [30:0]          acc_in;
    logic [FRAC_BITS-1:0] fr_in;
    logic [4:0]           n_in;
    logic                 big_in;
    logic                 v_in;
    logic [61:0]          prod;

    if (i == 1) begin : g_head
      assign acc_in = 31'd1 << 30;
      assign fr_in  = in_e[FRAC_BITS-1:0];
      assign n_in   = in_e[28:24];
      assign big_in = in_big;
      assign v_in   = in_valid;
    end else begin : g_body
      assign acc_in = acc_r[i-1];
      assign fr_in  = fr_r[i-1];
      assign n_in   = n_r[i-1];
      assign big_in = big_r[i-1];
      assign v_in   = v_r[i-1];
    end

    assign prod = acc_in * ROOT_TAB[i];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      acc_r[i] <= fr_in[FRAC_BITS - i] ? prod[60:30] : acc_in;
      fr_r[i]  <= fr_in;
      n_r[i]   <= n_in;
      big_r[i] <= big_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= v_r[FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    f_r <= big_r[FRAC_BITS] ? '0 : (acc_r[FRAC_BITS] >> n_r[FRAC_BITS]);
  end

  assign out_valid = f_v_r;
  assign out_f     = f_r;

endmodule

`default_nettype wire

// ----- hw/rtl/gel_two_length_scattering.sv -----
// top level of the two-length-scale gel scattering function pipeline
`default_nettype none

// Computes I = Ls / (1 + ((s+1)/3) q^2 zeta^2)^(s/2) + Gs exp(-q^2 R^2 / 3) + bg
// for each scattering vector (qx, qy); one-dimensional use drives qy with zero.
// Input: a transaction is taken at a clock edge with start high and busy low.
// busy is high only during reset and in the cycle after it, so one vector can enter every cycle.
// Output: each result sits on out_data for exactly one cycle with out_strobe high,
// in input order. The receiver cannot stall the block and no stall exists inside it.
// Throughput is one vector per cycle; the pipeline length comes mostly from the
// chain of 24 squaring stages of the logarithm, 24 root-multiply stages of the
// exponential, 8 byte stages of the divide by three and the split wide multiplies.
// Configuration: cfg_we writes register cfg_index with cfg_wdata. Writes are to be
// made only while no transaction is in flight; the block does not enforce this.
// Unknown indexes are ignored. Reset loads the default register values and empties the pipeline.
module gel_two_length_scattering (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  gtls_pkg::in_t                 in_data,
  output logic                          out_strobe,
  output gtls_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic [gtls_pkg::IDX_W-1:0]    cfg_index,
  input  logic [gtls_pkg::CFG_W-1:0]    cfg_wdata
);
  import gtls_pkg::*;

  // configuration registers
  logic signed [31:0] lorentz_scale_r;
  logic signed [31:0] guinier_scale_r;
  logic [23:0]        correlation_length_r;
  logic [23:0]        gyration_radius_r;
  logic signed [15:0] scaling_exponent_r;
  logic signed [31:0] background_level_r;
  logic               busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lorentz_scale_r      <= RST_LORENTZ_SCALE;
      guinier_scale_r      <= RST_GUINIER_SCALE;
      correlation_length_r <= RST_CORRELATION_LENGTH;
      gyration_radius_r    <= RST_GYRATION_RADIUS;
      scaling_exponent_r   <= RST_SCALING_EXPONENT;
      background_level_r   <= RST_BACKGROUND_LEVEL;
      busy_r               <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_LORENTZ_SCALE:      lorentz_scale_r      <= cfg_wdata;
          REG_GUINIER_SCALE:      guinier_scale_r      <= cfg_wdata;
          REG_CORRELATION_LENGTH: correlation_length_r <= cfg_wdata[23:0];
          REG_GYRATION_RADIUS:    gyration_radius_r    <= cfg_wdata[23:0];
          REG_SCALING_EXPONENT:   scaling_exponent_r   <= cfg_wdata[15:0];
          REG_BACKGROUND_LEVEL:   background_level_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign busy = busy_r;

  // registered values derived from the configuration; steady in flight only if no write is made then
  logic [14:0] us_r;
  logic [15:0] k_r;
  logic [47:0] z2_r;
  logic [47:0] rg2_r;
  logic [31:0] lmag_r;
  logic [31:0] gmag_r;
  logic        lneg_r;
  logic        gneg_r;
  logic [14:0] s_eff;
  logic [47:0] z2_full;
  logic [47:0] rg2_full;

  assign s_eff    = (scaling_exponent_r[15] || scaling_exponent_r == '0) ?
                    EXP_DEFAULT : scaling_exponent_r[14:0];
  assign z2_full  = correlation_length_r * correlation_length_r;
  assign rg2_full = gyration_radius_r * gyration_radius_r;

  always_ff @(posedge clk) begin
    us_r   <= s_eff;
    k_r    <= {1'b0, s_eff} + ONE_Q12;
    z2_r   <= z2_full;
    rg2_r  <= rg2_full;
    lmag_r <= lorentz_scale_r[31] ? (~lorentz_scale_r + 32'd1) : lorentz_scale_r;
    gmag_r <= guinier_scale_r[31] ? (~guinier_scale_r + 32'd1) : guinier_scale_r;
    lneg_r <= lorentz_scale_r[31];
    gneg_r <= guinier_scale_r[31];
  end

  // valid bits of the front stages, index = stage
  logic [16:0] v_r;
  logic        accept;

  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[15:0], accept};
    end
  end

  // stage 0: capture
  logic signed [23:0] qx0_r;
  logic signed [23:0] qy0_r;

  always_ff @(posedge clk) begin
    qx0_r <= in_data.qx;
    qy0_r <= in_data.qy;
  end

  // stage 1: squares of the magnitudes
  logic [23:0] ax;
  logic [23:0] ay;
  logic [47:0] sqx_full;
  logic [47:0] sqy_full;
  logic [46:0] sqx_r;
  logic [46:0] sqy_r;

  assign ax       = qx0_r[23] ? (~qx0_r + 24'd1) : qx0_r;
  assign ay       = qy0_r[23] ? (~qy0_r + 24'd1) : qy0_r;
  assign sqx_full = ax * ay_one(ax);
  assign sqy_full = ay * ay_one(ay);

  function automatic logic [23:0] ay_one(input logic [23:0] v);
    return v;
  endfunction

  always_ff @(posedge clk) begin
    sqx_r <= sqx_full[46:0];
    sqy_r <= sqy_full[46:0];
  end

  // stage 2: q squared
  logic [47:0] q2_r;

  always_ff @(posedge clk) begin
    q2_r <= {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  // stage 3: partial products of q^2 with zeta^2 and R^2
  logic [47:0] pz00, pz01, pz10, pz11;
  logic [47:0] pr00, pr01, pr10, pr11;
  logic [47:0] pz00_r, pz01_r, pz10_r, pz11_r;
  logic [47:0] pr00_r, pr01_r, pr10_r, pr11_r;

  assign pz00 = q2_r[23:0]  * z2_r[23:0];
  assign pz01 = q2_r[23:0]  * z2_r[47:24];
  assign pz10 = q2_r[47:24] * z2_r[23:0];
  assign pz11 = q2_r[47:24] * z2_r[47:24];
  assign pr00 = q2_r[23:0]  * rg2_r[23:0];
  assign pr01 = q2_r[23:0]  * rg2_r[47:24];
  assign pr10 = q2_r[47:24] * rg2_r[23:0];
  assign pr11 = q2_r[47:24] * rg2_r[47:24];

  always_ff @(posedge clk) begin
    pz00_r <= pz00;
    pz01_r <= pz01;
    pz10_r <= pz10;
    pz11_r <= pz11;
    pr00_r <= pr00;
    pr01_r <= pr01;
    pr10_r <= pr10;
    pr11_r <= pr11;
  end

  // stage 4: middle sums
  logic [48:0] zmid_r;
  logic [48:0] rmid_r;
  logic [95:0] zouter_r;
  logic [95:0] router_r;

  always_ff @(posedge clk) begin
    zmid_r   <= {1'b0, pz01_r} + {1'b0, pz10_r};
    rmid_r   <= {1'b0, pr01_r} + {1'b0, pr10_r};
    zouter_r <= {pz11_r, pz00_r};
    router_r <= {pr11_r, pr00_r};
  end

  // stage 5: full products, scaled to Q.24
  logic [95:0] ztot;
  logic [95:0] rtot;
  logic [53:0] a_r;
  logic [53:0] d_r;

  assign ztot = zouter_r + {23'b0, zmid_r, 24'b0};
  assign rtot = router_r + {23'b0, rmid_r, 24'b0};

  always_ff @(posedge clk) begin
    a_r <= ztot[95:42];
    d_r <= rtot[95:42];
  end

  // stage 6: a times (s + 1.0), split in halves
  logic [42:0] palo;
  logic [42:0] pahi;
  logic [42:0] palo_r;
  logic [42:0] pahi_r;
  logic [53:0] d6_r;

  assign palo = a_r[26:0]  * k_r;
  assign pahi = a_r[53:27] * k_r;

  always_ff @(posedge clk) begin
    palo_r <= palo;
    pahi_r <= pahi;
    d6_r   <= d_r;
  end

  // stage 7: recombine and drop 12 fraction bits
  logic [69:0] tsum;
  logic [57:0] t_r;
  logic [53:0] d7_r;

  assign tsum = {pahi_r, 27'b0} + {27'b0, palo_r};

  always_ff @(posedge clk) begin
    t_r  <= tsum[69:12];
    d7_r <= d6_r;
  end

  // stages 8..15: divide both values by three, one byte a stage from the top
  logic [63:0] tw_r [1:DIV_STAGES-1];
  logic [63:0] dw_r [1:DIV_STAGES-1];
  logic [1:0]  tr_r [1:DIV_STAGES-1];
  logic [1:0]  dr_r [1:DIV_STAGES-1];
  logic [63:0] tq_r [1:DIV_STAGES];
  logic [63:0] dq_r [1:DIV_STAGES];

  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
    logic [63:0] tw_in;
    logic [63:0] dw_in;
    logic [1:0]  tr_in;
    logic [1:0]  dr_in;
    logic [63:0] tq_in;
    logic [63:0] dq_in;
    logic [9:0]  tstep;
    logic [9:0]  dstep;

    if (j == 1) begin : g_head
      assign tw_in = {6'b0, t_r};
      assign dw_in = {10'b0, d7_r};
      assign tr_in = '0;
      assign dr_in = '0;
      assign tq_in = '0;
      assign dq_in = '0;
    end else begin : g_body
      assign tw_in = tw_r[j-1];
      assign dw_in = dw_r[j-1];
      assign tr_in = tr_r[j-1];
      assign dr_in = dr_r[j-1];
      assign tq_in = tq_r[j-1];
      assign dq_in = dq_r[j-1];
    end

    assign tstep = div3_step(tr_in, tw_in[63:56]);
    assign dstep = div3_step(dr_in, dw_in[63:56]);

    always_ff @(posedge clk) begin
      tq_r[j] <= {tq_in[55:0], tstep[9:2]};
      dq_r[j] <= {dq_in[55:0], dstep[9:2]};
    end

    if (j < DIV_STAGES) begin : g_carry
      always_ff @(posedge clk) begin
        tw_r[j] <= {tw_in[55:0], 8'b0};
        dw_r[j] <= {dw_in[55:0], 8'b0};
        tr_r[j] <= tstep[1:0];
        dr_r[j] <= dstep[1:0];
      end
    end
  end

  // stage 16: log base and the Guinier exponent partial products
  logic [57:0] b_r;
  logic [57:0] glo;
  logic [56:0] ghi;
  logic [57:0] glo_r;
  logic [56:0] ghi_r;

  assign glo = dq_r[DIV_STAGES][26:0]  * LOG2E_Q30;
  assign ghi = dq_r[DIV_STAGES][52:27] * LOG2E_Q30;

  always_ff @(posedge clk) begin
    b_r   <= tq_r[DIV_STAGES][57:0] + (58'd1 << FRAC_BITS);
    glo_r <= glo;
    ghi_r <= ghi;
  end

  // stage 17: Guinier exponent, then held until the Lorentz exponent is ready
  logic [83:0] gsum;
  logic [53:0] e2_r;
  logic [53:0] e2_dl_r [1:LOG_STAGES];

  assign gsum = {ghi_r, 27'b0} + {26'b0, glo_r};

  always_ff @(posedge clk) begin
    e2_r       <= gsum[83:30];
    e2_dl_r[1] <= e2_r;
    for (int i = 2; i <= LOG_STAGES; i++) begin
      e2_dl_r[i] <= e2_dl_r[i-1];
    end
  end

  logic        log_valid;
  logic [29:0] log_b;

  gtls_log2 u_log2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_r[16]),
    .in_b      (b_r),
    .out_valid (log_valid),
    .out_log   (log_b)
  );

  // stage 43: Lorentz exponent
  logic [44:0] e1_full;
  logic [31:0] e1_r;
  logic        e_v_r;

  assign e1_full = us_r * log_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else begin
      e_v_r <= log_valid;
    end
  end

  always_ff @(posedge clk) begin
    e1_r <= e1_full[44:13];
  end

  logic        fl_valid;
  logic        fg_valid;
  logic [30:0] fl;
  logic [30:0] fg;

  gtls_pow2 u_pow2_lorentz (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (e_v_r),
    .in_e      ({22'b0, e1_r}),
    .out_valid (fl_valid),
    .out_f     (fl)
  );

  gtls_pow2 u_pow2_guinier (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (e_v_r),
    .in_e      (e2_dl_r[LOG_STAGES]),
    .out_valid (fg_valid),
    .out_f     (fg)
  );

  // stage 69: scaled term magnitudes
  logic [62:0] lprod;
  logic [62:0] gprod;
  logic [32:0] lterm_r;
  logic [32:0] gterm_r;
  logic        t_v_r;

  assign lprod = lmag_r * fl;
  assign gprod = gmag_r * fg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
    end else begin
      t_v_r <= fl_valid && fg_valid;
    end
  end

  always_ff @(posedge clk) begin
    lterm_r <= lprod[62:30];
    gterm_r <= gprod[62:30];
  end

  // stage 70: signed sum with the background
  logic signed [34:0] tl;
  logic signed [34:0] tg;
  logic signed [34:0] sum_r;
  logic               s_v_r;

  assign tl = lneg_r ? -$signed({2'b00, lterm_r}) : $signed({2'b00, lterm_r});
  assign tg = gneg_r ? -$signed({2'b00, gterm_r}) : $signed({2'b00, gterm_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else begin
      s_v_r <= t_v_r;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= tl + tg + $signed({{3{background_level_r[31]}}, background_level_r});
  end

  // stage 71: clip to the output range
  out_t out_nxt;
  out_t out_r;
  logic out_strobe_r;

  always_comb begin
    if (sum_r > 35'sd2147483647) begin
      out_nxt.intensity = 32'sh7fff_ffff;
      out_nxt.saturated = 1'b1;
    end else if (sum_r < -35'sd2147483648) begin
      out_nxt.intensity = 32'sh8000_0000;
      out_nxt.saturated = 1'b1;
    end else begin
      out_nxt.intensity = sum_r[31:0];
      out_nxt.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule

`default_nettype wire

// ----- hw/rtl/gtls_checker.sv -----
// port-level checks of the gel scattering pipeline, bound to the top level
`default_nettype none

module gtls_props (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_strobe,
  input gtls_pkg::out_t             out_data
);
  import gtls_pkg::*;

  // every input transaction gives one result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_strobe)
    else $error("missing result after input transaction");

  // no result without an input transaction that caused it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LATENCY))
    else $error("result without input transaction");

  // a clipped result sits at one end of the range
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.saturated) |->
      (out_data.intensity == 32'sh7fff_ffff || out_data.intensity == 32'sh8000_0000))
    else $error("saturated result not at range end");

  // the block takes a transaction every cycle once out of reset
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

endmodule

bind gel_two_length_scattering gtls_props u_gtls_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);

`default_nettype wire
